/* src/fsps_pkg.sv */
`default_nettype none
package fsps_pkg;

    localparam int DEF_MAX_CELLS   = 8;
    localparam int DEF_VALUE_WIDTH = 32;
    localparam int MIN_PATTERN     = 3;
    localparam logic [15:0] DEFAULT_TOL = 16'd16384;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_CELLS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CUMULATIVE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HITS      = 3'd4;

    typedef struct packed {
        logic [31:0] flux_value;
        logic        start_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic [31:0] hit_index;
        logic [39:0] cell_period;
        logic [15:0] max_deviation;
    } out_item_t;

endpackage
`default_nettype wire

/* src/flux_sync_pattern_search.sv */
// Sequence for a tested window: S_SUM adds the window cells, S_TOLM and S_TOLW form the tolerance
// product, S_MULA/S_MULB/S_DIFF/S_CMP check each cell, S_DIVC and S_DIVE divide, S_DONE emits.
// Throughput: one request at a time; in_stall stays high while a window is tested and
// while a finished hit waits for a stalled result to leave.
// One shared multiplier (SD_W by 16 bits) and a bit-serial restoring divider do the arithmetic.
// rst_n (async, active low) restores register defaults and empties the window.
`default_nettype none
module flux_sync_pattern_search
    import fsps_pkg::*;
#(
    parameter int MAX_CELLS   = DEF_MAX_CELLS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_item_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_item_t                 out_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data
);

    localparam int VW    = VALUE_WIDTH;
    localparam int IDX_W = $clog2(MAX_CELLS);
    localparam int FIL_W = $clog2(MAX_CELLS + 1);
    localparam int SD_W  = VW + IDX_W;
    localparam int SK_W  = 8 + IDX_W;
    localparam int P_W   = SD_W + 16;
    localparam int Q_W   = SD_W + 8;
    localparam int CNT_W = $clog2(Q_W + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SUM, S_TOLM, S_TOLW, S_MULA, S_MULB, S_DIFF, S_CMP,
        S_DIVC, S_DIVE, S_DONE
    } state_t;

    // configuration
    logic [63:0] cells_reg;
    logic [3:0]  len_reg;
    logic [15:0] tol_reg;
    logic        cum_reg;
    logic [15:0] max_hits_reg;

    // block state
    state_t            state_reg;
    logic [VW-1:0]     prev_reg;
    logic [VW-1:0]     win_reg [MAX_CELLS];
    logic [FIL_W-1:0]  fill_reg;
    logic [31:0]       item_idx_reg;
    logic [15:0]       hits_reg;
    logic [31:0]       cur_reg;

    // datapath
    logic [IDX_W-1:0]  idx_reg;
    logic [SD_W-1:0]   sum_d_reg;
    logic [SK_W-1:0]   sum_k_reg;
    logic [P_W-1:0]    prod_reg;
    logic [P_W-1:0]    tol_prod_reg;
    logic [P_W-1:0]    a_reg;
    logic [P_W-1:0]    num_reg;
    logic [P_W-1:0]    worst_reg;
    logic [39:0]       clock_reg;
    logic [15:0]       err_reg;

    // divider
    logic [SD_W-1:0]   rem_reg;
    logic [Q_W-1:0]    dvd_reg;
    logic [Q_W-1:0]    quo_reg;
    logic [SD_W-1:0]   dsr_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic              out_valid_reg;
    out_item_t         out_data_reg;

    // input side
    logic              accept;
    logic [VW-1:0]     v;
    logic [VW-1:0]     prev_eff;
    logic [VW-1:0]     d;
    logic [FIL_W-1:0]  fill_eff;
    logic [FIL_W-1:0]  fill_new;
    logic [15:0]       hits_eff;
    logic [31:0]       cur;
    logic              len_ok;
    logic              test_go;

    logic [FIL_W-1:0]  base;
    logic [IDX_W-1:0]  rd_idx;
    logic [VW-1:0]     win_rd;
    logic [7:0]        k_i;
    logic [IDX_W-1:0]  last_idx;
    logic [15:0]       tol_eff;

    logic [SD_W-1:0]   mul_x;
    logic [15:0]       mul_y;

    logic [SD_W:0]     rem_sh;
    logic              q_bit;
    logic [SD_W-1:0]   rem_step;
    logic [Q_W-1:0]    quo_step;
    logic [63:0]       q64;
    logic [P_W+15:0]   num_sh;
    logic              out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        v        = in_data.flux_value[VW-1:0];
        prev_eff = in_data.start_of_buffer ? '0 : prev_reg;
        if (cum_reg)
            d = (v > prev_eff) ? v - prev_eff : '0;
        else
            d = v;
        fill_eff = in_data.start_of_buffer ? '0 : fill_reg;
        fill_new = (fill_eff >= FIL_W'(MAX_CELLS)) ? FIL_W'(MAX_CELLS) : fill_eff + 1'b1;
        hits_eff = in_data.start_of_buffer ? '0 : hits_reg;
        cur      = in_data.start_of_buffer ? '0 : item_idx_reg;
        len_ok   = (len_reg >= 4'(MIN_PATTERN)) && ({28'd0, len_reg} <= 32'(MAX_CELLS));
        test_go  = len_ok && ({28'd0, len_reg} <= 32'(fill_new)) && (hits_eff < max_hits_reg);
    end

    always_comb
    begin
        base     = fill_reg - FIL_W'(len_reg);
        rd_idx   = IDX_W'(base + FIL_W'(idx_reg));
        win_rd   = win_reg[rd_idx];
        k_i      = cells_reg[8*idx_reg +: 8];
        last_idx = IDX_W'(len_reg - 4'd1);
        tol_eff  = (tol_reg == '0) ? DEFAULT_TOL : tol_reg;
    end

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_TOLM:
            begin
                mul_x = sum_d_reg;
                mul_y = tol_eff;
            end
            S_MULA:
            begin
                mul_x = SD_W'(win_rd);
                mul_y = 16'(sum_k_reg);
            end
            S_MULB:
            begin
                mul_x = sum_d_reg;
                mul_y = 16'(k_i);
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    // one restoring-division step
    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[Q_W-1]};
        q_bit    = (rem_sh >= {1'b0, dsr_reg});
        rem_step = q_bit ? SD_W'(rem_sh - {1'b0, dsr_reg}) : rem_sh[SD_W-1:0];
        quo_step = {quo_reg[Q_W-2:0], q_bit};
        q64      = 64'(quo_step);
        num_sh   = {num_reg, 16'd0};
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= P_W'(mul_x * mul_y);
        if (accept)
        begin
            if (fill_eff >= FIL_W'(MAX_CELLS))
            begin
                for (int i = 1; i < MAX_CELLS; i++)
                    win_reg[i-1] <= win_reg[i];
                win_reg[MAX_CELLS-1] <= d;
            end
            else
            begin
                win_reg[IDX_W'(fill_eff)] <= d;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_reg     <= '0;
            len_reg       <= 4'd3;
            tol_reg       <= DEFAULT_TOL;
            cum_reg       <= 1'b0;
            max_hits_reg  <= 16'hFFFF;
            state_reg     <= S_IDLE;
            prev_reg      <= '0;
            fill_reg      <= '0;
            item_idx_reg  <= '0;
            hits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PATTERN_CELLS: cells_reg    <= cfg_data;
                    CFG_PATTERN_LEN:   len_reg      <= cfg_data[3:0];
                    CFG_TOLERANCE:     tol_reg      <= cfg_data[15:0];
                    CFG_CUMULATIVE:    cum_reg      <= cfg_data[0];
                    CFG_MAX_HITS:      max_hits_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end

            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        prev_reg     <= v;
                        fill_reg     <= fill_new;
                        item_idx_reg <= cur + 32'd1;
                        hits_reg     <= hits_eff;
                        cur_reg      <= cur;
                        idx_reg      <= '0;
                        sum_d_reg    <= '0;
                        sum_k_reg    <= '0;
                        state_reg    <= test_go ? S_SUM : S_IDLE;
                    end
                end
                S_SUM:
                begin
                    sum_d_reg <= sum_d_reg + SD_W'(win_rd);
                    sum_k_reg <= sum_k_reg + SK_W'(k_i);
                    idx_reg   <= idx_reg + 1'b1;
                    if (idx_reg == last_idx)
                        state_reg <= S_TOLM;
                end
                S_TOLM:
                begin
                    // zero cell sum or zero interval sum: no hit
                    if (sum_d_reg == '0 || sum_k_reg == '0)
                        state_reg <= S_IDLE;
                    else
                        state_reg <= S_TOLW;
                end
                S_TOLW:
                begin
                    tol_prod_reg <= prod_reg;
                    idx_reg      <= '0;
                    worst_reg    <= '0;
                    state_reg    <= S_MULA;
                end
                S_MULA:
                begin
                    state_reg <= S_MULB;
                end
                S_MULB:
                begin
                    a_reg     <= prod_reg;
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    num_reg   <= (a_reg > prod_reg) ? a_reg - prod_reg : prod_reg - a_reg;
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (num_sh > (P_W+16)'(tol_prod_reg))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        if (num_reg > worst_reg)
                            worst_reg <= num_reg;
                        if (idx_reg == last_idx)
                        begin
                            rem_reg   <= '0;
                            dvd_reg   <= {sum_d_reg, 8'd0};
                            quo_reg   <= '0;
                            dsr_reg   <= SD_W'(sum_k_reg);
                            cnt_reg   <= CNT_W'(Q_W);
                            state_reg <= S_DIVC;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_MULA;
                        end
                    end
                end
                S_DIVC:
                begin
                    if (cnt_reg == CNT_W'(1))
                    begin
                        clock_reg <= (q64 > 64'hFF_FFFF_FFFF) ? '1 : q64[39:0];
                        // worst < sum_d, so the error quotient fits 16 bits
                        rem_reg   <= SD_W'(worst_reg);
                        dvd_reg   <= '0;
                        quo_reg   <= '0;
                        dsr_reg   <= sum_d_reg;
                        cnt_reg   <= CNT_W'(16);
                        state_reg <= S_DIVE;
                    end
                    else
                    begin
                        rem_reg <= rem_step;
                        dvd_reg <= {dvd_reg[Q_W-2:0], 1'b0};
                        quo_reg <= quo_step;
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                S_DIVE:
                begin
                    rem_reg <= rem_step;
                    dvd_reg <= {dvd_reg[Q_W-2:0], 1'b0};
                    quo_reg <= quo_step;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        err_reg   <= (q64 > 64'hFFFF) ? 16'hFFFF : q64[15:0];
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // result register only changes once the previous hit has left
                    if (out_free)
                    begin
                        out_data_reg.hit_index     <= cur_reg - 32'(len_reg - 4'd1);
                        out_data_reg.cell_period   <= clock_reg;
                        out_data_reg.max_deviation <= err_reg;
                        fill_reg                   <= '0;
                        hits_reg                   <= hits_reg + 16'd1;
                        state_reg                  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* src/fsps_checker.sv */
`default_nettype none
module fsps_checker
    import fsps_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_stall,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire out_item_t            out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // handshake outputs are always driven
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_stall, out_valid}))
        else $error("handshake output unknown");

    // a new result only comes out of a running test
    a_rose: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a request in work");

endmodule

bind flux_sync_pattern_search fsps_checker u_fsps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire

/* dv/tb_flux_sync_pattern_search.sv */
`default_nettype none
module tb_flux_sync_pattern_search;
    timeunit 1ns;
    timeprecision 1ps;
    import fsps_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PATTERN_CELLS;
    logic [63:0] cfg_data = '0;

    flux_sync_pattern_search dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state
    logic [63:0] cells_q;
    logic [3:0]  len_q;
    logic [15:0] tol_q;
    logic        cumul_q;
    logic [15:0] max_hits_q;
    logic [31:0] prev_time;
    logic [31:0] win [8];
    int unsigned win_fill;
    logic [31:0] buf_index;
    logic [15:0] hit_count;

    in_item_t  pending_requests [$];
    out_item_t expected_hits [$];
    int  errors = 0;
    int  send_idle_pct = 0;
    int  stall_pct = 0;
    bit  sending_done = 1'b0;

    function automatic logic [7:0] cell_at(int i);
        return cells_q[8*i +: 8];
    endfunction

    task automatic predict_hit(input in_item_t req);
        logic [31:0] d;
        logic [31:0] cur;
        logic [63:0] sum_d, sum_k, worst, tol, a, b, num, clock, err;
        int unsigned base;
        bit ok;
        if (req.start_of_buffer)
        begin
            prev_time = '0;
            for (int i = 0; i < 8; i++) win[i] = '0;
            win_fill = 0;
            buf_index = '0;
            hit_count = '0;
        end
        if (cumul_q)
            d = (req.flux_value > prev_time) ? req.flux_value - prev_time : 32'd0;
        else
            d = req.flux_value;
        prev_time = req.flux_value;
        cur = buf_index;
        buf_index = buf_index + 32'd1;
        if (win_fill >= 8)
        begin
            for (int i = 1; i < 8; i++) win[i-1] = win[i];
            win[7] = d;
        end
        else
        begin
            win[win_fill] = d;
            win_fill++;
        end
        if (len_q < 3 || len_q > 8 || win_fill < len_q || hit_count >= max_hits_q)
            return;
        base = win_fill - len_q;
        sum_d = 0;
        sum_k = 0;
        worst = 0;
        for (int i = 0; i < len_q; i++)
        begin
            sum_d += win[base+i];
            sum_k += cell_at(i);
        end
        if (sum_k == 0 || sum_d == 0)
            return;
        tol = (tol_q != 0) ? tol_q : DEFAULT_TOL;
        ok = 1'b1;
        for (int i = 0; i < len_q; i++)
        begin
            a = win[base+i] * sum_k;
            b = cell_at(i) * sum_d;
            num = (a > b) ? a - b : b - a;
            if (num * 65536 > tol * sum_d)
                ok = 1'b0;
            else if (num > worst)
                worst = num;
            if (!ok)
                break;
        end
        if (!ok)
            return;
        clock = (sum_d * 256) / sum_k;
        if (clock > 64'hFF_FFFF_FFFF)
            clock = 64'hFF_FFFF_FFFF;
        err = (worst * 65536) / sum_d;
        if (err > 64'hFFFF)
            err = 64'hFFFF;
        expected_hits.push_back('{hit_index: cur - (len_q - 4'd1),
                                  cell_period: clock[39:0], max_deviation: err[15:0]});
        hit_count = hit_count + 16'd1;
        win_fill = 0;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_hit(in_data);
            if (!in_valid || !in_stall)
            begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_requests.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_hits.size() == 0)
            begin
                $display("%t unexpected hit: got %h", $time, out_data);
                errors++;
            end
            else
            begin
                out_item_t exp_hit;
                exp_hit = expected_hits.pop_front();
                if (out_data.hit_index !== exp_hit.hit_index)
                begin
                    $display("%t hit_index exp %h got %h", $time, exp_hit.hit_index,
                             out_data.hit_index);
                    errors++;
                end
                if (out_data.cell_period !== exp_hit.cell_period)
                begin
                    $display("%t cell_period exp %h got %h", $time,
                             exp_hit.cell_period, out_data.cell_period);
                    errors++;
                end
                if (out_data.max_deviation !== exp_hit.max_deviation)
                begin
                    $display("%t max_deviation exp %h got %h", $time, exp_hit.max_deviation,
                             out_data.max_deviation);
                    errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_requests.size() > 0 || in_valid || expected_hits.size() > 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PATTERN_CELLS: cells_q = val;
            CFG_PATTERN_LEN:   len_q = val[3:0];
            CFG_TOLERANCE:     tol_q = val[15:0];
            CFG_CUMULATIVE:    cumul_q = val[0];
            CFG_MAX_HITS:      max_hits_q = val[15:0];
            default: ;
        endcase
    endtask

    task automatic push_req(input logic [31:0] v, input logic sob);
        pending_requests.push_back('{flux_value: v, start_of_buffer: sob});
    endtask

    // a noisy copy of the pattern scaled by a random clock, mostly well-formed
    task automatic push_frame(input bit cumul, inout logic [31:0] t);
        int unsigned clk_ticks;
        logic [31:0] d;
        clk_ticks = $urandom_range(20, 200);
        for (int i = 0; i < len_q; i++)
        begin
            d = cell_at(i) * clk_ticks;
            if ($urandom_range(3) == 0)
                d = d + $urandom_range(clk_ticks / 3) - clk_ticks / 6;
            if ($urandom_range(15) == 0)
                d = $urandom;
            t = cumul ? t + d : d;
            push_req(t, 1'b0);
        end
    endtask

    task automatic random_phase(input int n);
        logic [31:0] t;
        int sent;
        t = 0;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(9) < 7)
            begin
                push_frame(cumul_q, t);
                sent += len_q;
            end
            else
            begin
                if ($urandom_range(7) == 0)
                    t = $urandom;
                else
                    t = cumul_q ? t + $urandom_range(300) : $urandom_range(600);
                if ($urandom_range(4) == 0)
                    t = $urandom;
                push_req(t, ($urandom_range(30) == 0));
                if (pending_requests[$].start_of_buffer)
                    t = pending_requests[$].flux_value;
                sent++;
            end
        end
        wait_drained();
    endtask

    initial
    begin
        logic [31:0] t;
        cells_q = '0;
        len_q = 4'd3;
        tol_q = 16'd16384;
        cumul_q = 1'b0;
        max_hits_q = 16'hFFFF;
        prev_time = '0;
        for (int i = 0; i < 8; i++) win[i] = '0;
        win_fill = 0;
        buf_index = '0;
        hit_count = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset pattern is all zero cells: never a hit; no buffer mark at first
        push_req(32'd100, 1'b0);
        push_req(32'd200, 1'b0);
        push_req(32'd300, 1'b0);
        wait_drained();

        write_reg(CFG_PATTERN_CELLS, 64'h0403_0201_0302_0402);
        write_reg(CFG_PATTERN_LEN, 64'd3);
        push_req(32'd200, 1'b1);
        push_req(32'd400, 1'b0);
        push_req(32'd100, 1'b0);
        push_req(32'hFFFF_FFFF, 1'b0);
        push_req(32'hFFFF_FFFF, 1'b0);
        push_req(32'h7FFF_FFFF, 1'b0);
        push_req(32'd0, 1'b0);
        push_req(32'd0, 1'b0);
        push_req(32'd0, 1'b0);
        wait_drained();

        // zero cell count element, default tolerance, bad lengths
        write_reg(CFG_PATTERN_CELLS, 64'hFF01_00FF_0200_0302);
        write_reg(CFG_TOLERANCE, 64'd0);
        push_req(32'd30, 1'b1);
        push_req(32'd0, 1'b0);
        push_req(32'd10, 1'b0);
        wait_drained();
        write_reg(CFG_PATTERN_LEN, 64'd2);
        push_req(32'd5, 1'b0);
        push_req(32'd5, 1'b0);
        push_req(32'd5, 1'b0);
        wait_drained();
        write_reg(CFG_PATTERN_LEN, 64'd15);
        push_req(32'd5, 1'b0);
        wait_drained();

        // cumulative mode with a non-increasing step; hit limit of one
        write_reg(CFG_PATTERN_LEN, 64'd8);
        write_reg(CFG_CUMULATIVE, 64'd1);
        write_reg(CFG_MAX_HITS, 64'd1);
        write_reg(CFG_TOLERANCE, 64'hFFFF);
        t = 32'd1000;
        push_req(t, 1'b1);
        push_frame(1'b1, t);
        push_frame(1'b1, t);
        push_req(32'd5, 1'b0);
        wait_drained();

        write_reg(CFG_MAX_HITS, 64'd0);
        push_frame(1'b1, t);
        wait_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 74; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 74; end
                default: begin send_idle_pct = 37; stall_pct = 37; end
            endcase
            write_reg(CFG_PATTERN_CELLS, {$urandom, $urandom} |
                      64'h0101_0101_0101_0101 & {$urandom, $urandom});
            if (ph == 7)
                write_reg(CFG_PATTERN_CELLS, 64'hFFFF_FFFF_FFFF_FFFF);
            write_reg(CFG_PATTERN_LEN, (ph == 0) ? 64'd3 : 64'(3 + $urandom_range(5)));
            write_reg(CFG_TOLERANCE, (ph == 5) ? 64'd1 : 64'($urandom_range(65535)));
            write_reg(CFG_CUMULATIVE, 64'(ph & 1));
            write_reg(CFG_MAX_HITS, (ph == 2) ? 64'd3 : 64'hFFFF);
            random_phase(250);
        end
        sending_done = 1'b1;
    end

    initial
    begin
        wait (sending_done);
        if (errors == 0)
            $display("tb_flux_sync_pattern_search: PASS");
        else
            $display("tb_flux_sync_pattern_search: FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb_flux_sync_pattern_search: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
